>>> hdl/wheel_speed_median_meter_assert.svh
// ----------------------------------------------------------------------------
// Wheel speed median meter assertion macros
// Concurrent check shorthands shared by the meter's RTL.
// ----------------------------------------------------------------------------
`ifndef WHEEL_SPEED_MEDIAN_METER_ASSERT_SVH
`define WHEEL_SPEED_MEDIAN_METER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsmm same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsmm next-cycle check failed");

`endif

>>> hdl/wsmm_pkg.sv
// ----------------------------------------------------------------------------
// Wheel speed median meter package
// Shared widths, constants and types of the meter.
// ----------------------------------------------------------------------------
package wsmm_pkg;

    localparam int NUM_WHEELS          = 4;
    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int SCALE_W             = 16;
    localparam int SPEED_W             = 24;
    localparam int FRAC_DROP           = 8;

    localparam logic [SCALE_W-1:0] SPEED_SCALE_RESET = 16'd8062;
    localparam logic [SPEED_W-1:0] SPEED_TOP         = 24'd16776960;

    typedef logic [SCALE_W-1:0] scale_t;
    typedef logic [SPEED_W-1:0] speed_t;

endpackage

>>> hdl/wsmm_in_if.sv
// ----------------------------------------------------------------------------
// Wheel speed median meter input channel
// Valid/ready channel carrying one sample of the four pins and a window mark.
// ----------------------------------------------------------------------------
interface wsmm_in_if;

    logic valid;
    logic ready;
    logic pin_front_left;
    logic pin_front_right;
    logic pin_rear_left;
    logic pin_rear_right;
    logic window_end;

    modport source (
        output valid,
        input  ready,
        output pin_front_left,
        output pin_front_right,
        output pin_rear_left,
        output pin_rear_right,
        output window_end
    );

    modport sink (
        input  valid,
        output ready,
        input  pin_front_left,
        input  pin_front_right,
        input  pin_rear_left,
        input  pin_rear_right,
        input  window_end
    );

endinterface

>>> hdl/wsmm_out_if.sv
// ----------------------------------------------------------------------------
// Wheel speed median meter result channel
// Valid/ready channel carrying four wheel speeds and the combined speed.
// ----------------------------------------------------------------------------
interface wsmm_out_if;

    logic            valid;
    logic            ready;
    wsmm_pkg::speed_t speed_front_left;
    wsmm_pkg::speed_t speed_front_right;
    wsmm_pkg::speed_t speed_rear_left;
    wsmm_pkg::speed_t speed_rear_right;
    wsmm_pkg::speed_t speed_combined;

    modport source (
        output valid,
        input  ready,
        output speed_front_left,
        output speed_front_right,
        output speed_rear_left,
        output speed_rear_right,
        output speed_combined
    );

    modport sink (
        input  valid,
        output ready,
        input  speed_front_left,
        input  speed_front_right,
        input  speed_rear_left,
        input  speed_rear_right,
        input  speed_combined
    );

endinterface

>>> hdl/wheel_speed_median_meter.sv
// ----------------------------------------------------------------------------
// Wheel speed median meter
// Pulse counting speed meter for four wheels with a median-of-four combine.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  - one item per pin sample: four sensor levels and window_end.
//            A falling edge on a pin bumps that wheel's saturating counter.
//   out_ch - one item per window_end item: four wheel speeds and the mean
//            of the middle two, all in 1/256 km/h.
//   speed_scale_we / speed_scale_data - write the km/h-per-pulse scale
//            (16 fraction bits); change it only while the meter is idle.
// Throughput: one input item per cycle while in_ch.ready is high; a
//   window_end item also passes a count snapshot stage, a multiply stage
//   (one count x scale product per wheel) and the combine stage.
// Path: a window_end item moves through the snapshot stage, the speed
//   stage and the result register before it shows on out_ch.
// Reset: counters, pin history and all stage valids clear; scale goes to
//   its reset value. A pin held low from reset is no edge.
// Stall: the result register holds while out_ch.ready is low; the stages
//   behind it fill and in_ch.ready drops only when the snapshot stage is
//   full and cannot move.
// ----------------------------------------------------------------------------
module wheel_speed_median_meter #(
    parameter int COUNT_WIDTH = wsmm_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    wsmm_in_if.sink            in_ch,
    wsmm_out_if.source         out_ch,
    input  logic               speed_scale_we,
    input  wsmm_pkg::scale_t   speed_scale_data
);

    import wsmm_pkg::*;

    // Product width before and after dropping fraction bits; the compare
    // width covers both the shifted product and the speed range.
    localparam int PROD_W = COUNT_WIDTH + SCALE_W;
    localparam int SHR_W  = PROD_W - FRAC_DROP;
    localparam int CMP_W  = (SHR_W > SPEED_W) ? SHR_W : SPEED_W;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    localparam count_t COUNT_TOP = {COUNT_WIDTH{1'b1}};

    // Configuration
    scale_t                 scale_reg;

    // Counting state
    logic [NUM_WHEELS-1:0]  prev_levels_reg;
    count_t                 counts_reg  [NUM_WHEELS];
    count_t                 counts_next [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]  levels_now;
    logic [NUM_WHEELS-1:0]  falling;

    // Stage 1: count snapshot of a finished window
    logic                   s1_valid_reg;
    count_t                 snap_reg [NUM_WHEELS];

    // Stage 2: per-wheel speeds
    logic                   s2_valid_reg;
    speed_t                 speed_reg  [NUM_WHEELS];
    speed_t                 speed_next [NUM_WHEELS];
    logic [PROD_W-1:0]      prod       [NUM_WHEELS];
    logic [CMP_W-1:0]       shr_ext    [NUM_WHEELS];

    // Stage 3: result register
    logic                   out_valid_reg;
    speed_t                 out_speed_reg [NUM_WHEELS];
    speed_t                 out_comb_reg;

    // Combine logic
    speed_t                 lo_a, hi_a, lo_b, hi_b, mid_lo, mid_hi;
    logic [SPEED_W:0]       mid_sum;
    speed_t                 comb_next;

    // Handshake and stage movement
    logic                   in_acc;
    logic                   win_acc;
    logic                   out_free;
    logic                   s2_free;
    logic                   s1_free;

    // Check terms
    logic                   counts_clear;
    logic                   comb_in_range;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;

    assign in_ch.ready = s1_free;
    assign in_acc      = in_ch.valid && s1_free;
    assign win_acc     = in_acc && in_ch.window_end;

    // Falling edge detect and saturating counters
    assign levels_now = {in_ch.pin_rear_right, in_ch.pin_rear_left,
                         in_ch.pin_front_right, in_ch.pin_front_left};
    assign falling    = prev_levels_reg & ~levels_now;

    always_comb
    begin
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            if (falling[i] && (counts_reg[i] != COUNT_TOP))
                counts_next[i] = counts_reg[i] + count_t'(1);
            else
                counts_next[i] = counts_reg[i];
        end
    end

    // Speed per wheel: (count * scale) >> 8, clamped to the speed range
    always_comb
    begin
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            prod[i]    = PROD_W'(snap_reg[i]) * PROD_W'(scale_reg);
            shr_ext[i] = CMP_W'(prod[i][PROD_W-1:FRAC_DROP]);
            if (shr_ext[i] > CMP_W'(SPEED_TOP))
                speed_next[i] = SPEED_TOP;
            else
                speed_next[i] = SPEED_W'(shr_ext[i]);
        end
    end

    // Middle two of four: sort each pair, then the larger low and the
    // smaller high are the middle values
    always_comb
    begin
        lo_a    = (speed_reg[0] < speed_reg[1]) ? speed_reg[0] : speed_reg[1];
        hi_a    = (speed_reg[0] < speed_reg[1]) ? speed_reg[1] : speed_reg[0];
        lo_b    = (speed_reg[2] < speed_reg[3]) ? speed_reg[2] : speed_reg[3];
        hi_b    = (speed_reg[2] < speed_reg[3]) ? speed_reg[3] : speed_reg[2];
        mid_lo  = (lo_a > lo_b) ? lo_a : lo_b;
        mid_hi  = (hi_a < hi_b) ? hi_a : hi_b;
        mid_sum = {1'b0, mid_lo} + {1'b0, mid_hi};
        comb_next = mid_sum[SPEED_W:1];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg       <= SPEED_SCALE_RESET;
            prev_levels_reg <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_WHEELS; i++)
                counts_reg[i] <= '0;
        end
        else
        begin
            if (speed_scale_we)
                scale_reg <= speed_scale_data;

            // Count every accepted sample; clear at the end of a window
            if (in_acc)
            begin
                prev_levels_reg <= levels_now;
                for (int i = 0; i < NUM_WHEELS; i++)
                    counts_reg[i] <= in_ch.window_end ? '0 : counts_next[i];
            end

            if (s1_free)
                s1_valid_reg <= win_acc;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (out_free)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // Payload stages: advance only when the stage ahead has room
    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            for (int i = 0; i < NUM_WHEELS; i++)
                snap_reg[i] <= counts_next[i];
        end
        if (s2_free)
        begin
            for (int i = 0; i < NUM_WHEELS; i++)
                speed_reg[i] <= speed_next[i];
        end
        if (out_free)
        begin
            for (int i = 0; i < NUM_WHEELS; i++)
                out_speed_reg[i] <= speed_reg[i];
            out_comb_reg <= comb_next;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.speed_front_left  = out_speed_reg[0];
    assign out_ch.speed_front_right = out_speed_reg[1];
    assign out_ch.speed_rear_left   = out_speed_reg[2];
    assign out_ch.speed_rear_right  = out_speed_reg[3];
    assign out_ch.speed_combined    = out_comb_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    assign counts_clear  = (counts_reg[0] == '0) && (counts_reg[1] == '0) &&
                           (counts_reg[2] == '0) && (counts_reg[3] == '0);
    assign comb_in_range = (out_comb_reg <= out_speed_reg[0]) ||
                           (out_comb_reg <= out_speed_reg[1]) ||
                           (out_comb_reg <= out_speed_reg[2]) ||
                           (out_comb_reg <= out_speed_reg[3]);

`include "wheel_speed_median_meter_assert.svh"

    // A window end clears every counter
    `WSMM_ASSERT_NEXT(a_window_clears, clk, rst_n, win_acc, counts_clear)

    // A window end always enters the snapshot stage
    `WSMM_ASSERT_NEXT(a_window_enters, clk, rst_n, win_acc, s1_valid_reg)

    // Combined speed never exceeds the fastest wheel
    `WSMM_ASSERT_NOW(a_comb_bounded, clk, rst_n, out_valid_reg, comb_in_range)

endmodule

>>> dv/wheel_speed_median_meter_tb.sv
// ----------------------------------------------------------------------------
// Wheel speed median meter testbench
// Drives pin samples and window marks into the meter, predicts every
// window's four wheel speeds and their median-of-four combine, and checks
// each result item field by field under random stalls on both channels.
// ----------------------------------------------------------------------------
module wheel_speed_median_meter_tb;

    import wsmm_pkg::*;

    localparam int CNT_W       = COUNT_WIDTH_DEFAULT;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_TAIL  = 8;
    localparam int PHASE_ITEMS = 300;

    typedef struct packed {
        speed_t front_left;
        speed_t front_right;
        speed_t rear_left;
        speed_t rear_right;
        speed_t combined;
    } window_speeds_t;

    // ------------------------------------------------------------------------
    // Window speed tracker: mirrors pin history, pulse counters and scale,
    // and holds the speeds each closed window is due to report.
    // ------------------------------------------------------------------------
    class window_speed_tracker;
        scale_t           scale;
        logic [3:0]       last_levels;
        logic [CNT_W-1:0] pulse_count[NUM_WHEELS];
        window_speeds_t   speeds_due[$];
        int unsigned      mismatches;

        function new();
            scale       = SPEED_SCALE_RESET;
            last_levels = '0;
            mismatches  = 0;
            foreach (pulse_count[i])
                pulse_count[i] = '0;
        endfunction

        function void set_scale(scale_t value);
            scale = value;
        endfunction

        function int unsigned waiting();
            return speeds_due.size();
        endfunction

        function speed_t wheel_speed(logic [CNT_W-1:0] count);
            logic [CNT_W+15:0] product;
            logic [CNT_W+15:0] shifted;
            product = {{16{1'b0}}, count} * {{CNT_W{1'b0}}, scale};
            shifted = product >> FRAC_DROP;
            if (shifted > SPEED_TOP)
                return SPEED_TOP;
            return speed_t'(shifted);
        endfunction

        function void take_sample(logic [3:0] levels, logic mark);
            logic [3:0]     falling;
            speed_t         sp[NUM_WHEELS];
            logic [25:0]    total;
            speed_t         hi;
            speed_t         lo;
            window_speeds_t w;
            falling = last_levels & ~levels;
            for (int i = 0; i < NUM_WHEELS; i++)
                if (falling[i] && pulse_count[i] != '1)
                    pulse_count[i] = pulse_count[i] + 1'b1;
            last_levels = levels;
            if (!mark)
                return;
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                sp[i] = wheel_speed(pulse_count[i]);
                pulse_count[i] = '0;
            end
            hi    = sp[0];
            lo    = sp[0];
            total = '0;
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                total = total + sp[i];
                if (sp[i] > hi)
                    hi = sp[i];
                if (sp[i] < lo)
                    lo = sp[i];
            end
            w.front_left  = sp[0];
            w.front_right = sp[1];
            w.rear_left   = sp[2];
            w.rear_right  = sp[3];
            w.combined    = speed_t'((total - hi - lo) >> 1);
            speeds_due.push_back(w);
        endfunction

        function void compare_speed(string field, speed_t want, speed_t got);
            if (want !== got)
            begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_speeds(window_speeds_t got);
            window_speeds_t want;
            if (speeds_due.size() == 0)
            begin
                $error("result item arrived with no window pending");
                mismatches++;
                return;
            end
            want = speeds_due.pop_front();
            compare_speed("speed_front_left", want.front_left, got.front_left);
            compare_speed("speed_front_right", want.front_right, got.front_right);
            compare_speed("speed_rear_left", want.rear_left, got.rear_left);
            compare_speed("speed_rear_right", want.rear_right, got.rear_right);
            compare_speed("speed_combined", want.combined, got.combined);
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    logic   speed_scale_we;
    scale_t speed_scale_data;

    wsmm_in_if  in_ch();
    wsmm_out_if out_ch();

    window_speed_tracker tracker;

    // Knobs shared between the stimulus and the receiver process.
    bit          src_idle_on;
    bit          snk_idle_on;
    int unsigned hold_off_len;
    int unsigned phase_items;
    int unsigned quiet_cycles;
    logic [3:0]  pin_levels;

    wheel_speed_median_meter #(
        .COUNT_WIDTH (CNT_W)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_ch            (in_ch),
        .out_ch           (out_ch),
        .speed_scale_we   (speed_scale_we),
        .speed_scale_data (speed_scale_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Monitor: note every accepted sample and check every accepted result at
    // the edge that moves it; also count edges where nothing moves at all.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                tracker.take_sample({in_ch.pin_rear_right, in_ch.pin_rear_left,
                                     in_ch.pin_front_right, in_ch.pin_front_left},
                                    in_ch.window_end);
            if (out_ch.valid && out_ch.ready)
                tracker.check_speeds('{front_left:  out_ch.speed_front_left,
                                       front_right: out_ch.speed_front_right,
                                       rear_left:   out_ch.speed_rear_left,
                                       rear_right:  out_ch.speed_rear_right,
                                       combined:    out_ch.speed_combined});
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: give up when nothing has moved for too long.
    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: take results, stall in random bursts when allowed, and hold
    // off for a long stretch when the stimulus asks for it.
    // ------------------------------------------------------------------------
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_len > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
                out_ch.ready <= 1'b1;
            end
            else if (snk_idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one sample; return at the edge that accepts it, valid still high.
    task automatic send_sample(logic [3:0] levels, logic mark);
        if (src_idle_on && $urandom_range(0, 9) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.pin_front_left  <= levels[0];
        in_ch.pin_front_right <= levels[1];
        in_ch.pin_rear_left   <= levels[2];
        in_ch.pin_rear_right  <= levels[3];
        in_ch.window_end      <= mark;
        pin_levels = levels;
        phase_items++;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // Drop valid and wait until every closed window has reported.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.waiting() != 0);
    endtask

    // Write the scale only with the meter empty and settled.
    task automatic write_scale(scale_t value);
        drain_results();
        repeat (DRAIN_TAIL) @(posedge clk);
        speed_scale_we   <= 1'b1;
        speed_scale_data <= value;
        @(posedge clk);
        speed_scale_we <= 1'b0;
        tracker.set_scale(value);
    endtask

    // One well-formed window: each wheel toggles at its own rate, the last
    // item carries the window mark.
    task automatic send_window(int unsigned len);
        int unsigned rate[NUM_WHEELS];
        logic [3:0]  lv;
        foreach (rate[i])
            rate[i] = $urandom_range(0, 4);
        for (int unsigned k = 0; k < len; k++)
        begin
            lv = pin_levels;
            for (int i = 0; i < NUM_WHEELS; i++)
                if ($urandom_range(1, 4) <= rate[i])
                    lv[i] = ~lv[i];
            send_sample(lv, k == len - 1);
        end
    endtask

    initial
    begin
        scale_t phase_scale[6];

        tracker = new();

        // Hold every input at a known value from time zero.
        rst_n                 = 1'b0;
        speed_scale_we        = 1'b0;
        speed_scale_data      = '0;
        in_ch.valid           = 1'b0;
        in_ch.pin_front_left  = 1'b0;
        in_ch.pin_front_right = 1'b0;
        in_ch.pin_rear_left   = 1'b0;
        in_ch.pin_rear_right  = 1'b0;
        in_ch.window_end      = 1'b0;
        out_ch.ready          = 1'b0;
        src_idle_on           = 1'b1;
        snk_idle_on           = 1'b1;
        hold_off_len          = 0;
        phase_items           = 0;
        quiet_cycles          = 0;
        pin_levels            = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: low pins after reset are no edge, then one edge each on
        // the window-end item itself (reset scale).
        send_sample(4'b0000, 1'b0);
        send_sample(4'b1111, 1'b0);
        send_sample(4'b0000, 1'b1);
        // Window with no edges at all.
        send_sample(4'b0000, 1'b1);
        // Rising edges and held-high levels do not count; the front-left, front-right and rear-left counts differ.
        send_sample(4'b0101, 1'b0);
        send_sample(4'b0101, 1'b0);
        send_sample(4'b0000, 1'b0);
        send_sample(4'b1111, 1'b0);
        send_sample(4'b1010, 1'b0);
        send_sample(4'b0000, 1'b0);
        send_sample(4'b0001, 1'b0);
        send_sample(4'b0000, 1'b1);

        // Largest scale, single pulses.
        write_scale(16'hFFFF);
        send_sample(4'b1111, 1'b0);
        send_sample(4'b0011, 1'b0);
        send_sample(4'b0000, 1'b1);

        // Zero scale zeroes every speed.
        write_scale(16'h0000);
        send_sample(4'b1111, 1'b0);
        send_sample(4'b0000, 1'b1);

        // Random phases, each under its own scale; the last one runs with no
        // idling on either side.
        phase_scale[0] = 16'd1;
        phase_scale[1] = scale_t'($urandom);
        phase_scale[2] = 16'hFFFF;
        phase_scale[3] = 16'h8000;
        phase_scale[4] = scale_t'($urandom);
        phase_scale[5] = SPEED_SCALE_RESET;

        for (int p = 0; p < 6; p++)
        begin
            write_scale(phase_scale[p]);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                // Mix stretches with and without idling, none at the end.
                src_idle_on = (p != 5) && ($urandom_range(0, 3) != 0);
                snk_idle_on = (p != 5) && ($urandom_range(0, 3) != 0);

                if (p == 1 && phase_items == 0)
                begin
                    // Hold the receiver off while window marks keep coming,
                    // so the stages fill and the input stalls.
                    hold_off_len = 80;
                    for (int k = 0; k < 40; k++)
                        send_sample(4'($urandom), 1'b1);
                end
                else if ($urandom_range(0, 19) == 0)
                begin
                    // Pause the sender until every result is home.
                    drain_results();
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    // Noise: arbitrary pins and marks, back-to-back windows.
                    repeat ($urandom_range(1, 12))
                        send_sample(4'($urandom), 1'($urandom_range(0, 2) == 0));
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    send_window($urandom_range(25, 200));
                end
                else
                begin
                    send_window($urandom_range(1, 24));
                end
            end
        end

        // Let everything drain, then give the pipeline time to show strays.
        drain_results();
        repeat (DRAIN_TAIL) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.waiting() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
